// File: sv/ild_pkg.sv
// Shared types, constants and helpers for the instruction length decoder.
`timescale 1ns / 1ps
package ild_pkg;

    localparam int WINDOW_BYTES = 15;
    localparam int LIMIT_BYTES = (WINDOW_BYTES < 15) ? WINDOW_BYTES : 15;
    localparam int WIN_BITS = 120;
    localparam int SCAN_STAGES = 4;
    localparam int HOPS_PER_STAGE = 4;

    localparam logic [4:0] LIMIT_POS = 5'(LIMIT_BYTES);

    localparam logic [7:0] BYTE_ESC = 8'h0f;
    localparam logic [7:0] BYTE_ESC_38 = 8'h38;
    localparam logic [7:0] BYTE_ESC_3A = 8'h3a;
    localparam logic [7:0] BYTE_VEX3 = 8'hc4;
    localparam logic [7:0] BYTE_XOP = 8'h8f;
    localparam logic [7:0] BYTE_VEX2 = 8'hc5;
    localparam logic [7:0] XOP_SEL_MASK = 8'h18;
    localparam logic [7:0] RIP_MASK = 8'hc7;
    localparam logic [3:0] REX_HI = 4'h4;
    localparam logic [7:0] BYTE_NOP = 8'h90;
    localparam logic [7:0] BYTE_NOPL = 8'h1f;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_OVERRUN = 2'd1;
    localparam logic [1:0] ERR_MAP = 2'd2;

    localparam logic [2:0] CLS_OTHER = 3'd0;
    localparam logic [2:0] CLS_NOP = 3'd1;
    localparam logic [2:0] CLS_JCC = 3'd2;
    localparam logic [2:0] CLS_JMP = 3'd3;
    localparam logic [2:0] CLS_CALL = 3'd4;
    localparam logic [2:0] CLS_LEA = 3'd5;

    typedef struct packed {
        logic [WIN_BITS-1:0] window;
        logic [4:0]  pos;
        logic [10:0] pfx;
        logic [7:0]  rv;
        logic [3:0]  vvvv;
        logic [4:0]  map;
        logic        vx;
        logic        ovf;
        logic        done;
    } scan_t;

    typedef struct packed {
        logic [WIN_BITS-1:0] window;
        logic [4:0]  pos;
        logic [7:0]  op;
        logic [4:0]  map;
        logic [10:0] pfx;
        logic [7:0]  rv;
        logic [3:0]  vvvv;
        logic        ovf;
        logic [1:0]  err;
    } opc_t;

    typedef struct packed {
        logic [4:0]  pos;
        logic [7:0]  op;
        logic [4:0]  map;
        logic [10:0] pfx;
        logic [7:0]  rv;
        logic [3:0]  vvvv;
        logic        ovf;
        logic [1:0]  err;
        logic [3:0]  disp;
        logic [3:0]  imm;
        logic        pic;
        logic [1:0]  form;
        logic [7:0]  modrm;
    } opnd_t;

    typedef struct packed {
        logic [3:0]  insn_length;
        logic [7:0]  opcode_byte;
        logic [4:0]  opcode_map;
        logic [10:0] prefix_mask;
        logic [7:0]  rex_vex_mask;
        logic [3:0]  extra_register;
        logic [1:0]  modrm_form;
        logic [3:0]  disp_bytes;
        logic [3:0]  imm_bytes;
        logic        rip_relative;
        logic [2:0]  insn_class;
        logic [1:0]  error_code;
    } result_t;

    // byte at a position; positions past the window read as zero
    function automatic logic [7:0] win_byte(input logic [WIN_BITS-1:0] w,
                                            input logic [4:0] p);
        logic [7:0] b;
        b = 8'h00;
        if (p < LIMIT_POS)
        begin
            b = w[{p[3:0], 3'b000} +: 8];
        end
        return b;
    endfunction

    // one step of the REX / VEX / XOP scan
    function automatic scan_t scan_hop(input scan_t s);
        scan_t n;
        logic [7:0] b;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] last;
        logic [4:0] p1;
        logic [4:0] p2;
        logic vex;
        n = s;
        last = 8'h00;
        vex = 1'b0;
        p1 = s.pos + 5'd1;
        p2 = s.pos + 5'd2;
        b = win_byte(s.window, s.pos);
        b1 = win_byte(s.window, p1);
        b2 = win_byte(s.window, p2);
        if (!s.done && !s.ovf)
        begin
            if (s.pos >= LIMIT_POS)
            begin
                n.ovf = 1'b1;
                n.done = 1'b1;
            end
            else if (b[7:4] == REX_HI)
            begin
                n.rv = {s.rv[7], b[0], b[1], b[2], b[3], s.rv[2:1], 1'b1};
                n.pos = p1;
            end
            else if (b == BYTE_XOP && p1 >= LIMIT_POS)
            begin
                n.ovf = 1'b1;
                n.done = 1'b1;
            end
            else if (b == BYTE_VEX3 || (b == BYTE_XOP && (b1 & XOP_SEL_MASK) != 8'h00))
            begin
                vex = 1'b1;
                n.ovf = (p2 >= LIMIT_POS);
                n.rv[6:3] = {~b1[5], ~b1[6], ~b1[7], b2[7]};
                if (b == BYTE_VEX3)
                begin
                    n.rv[1] = 1'b1;
                end
                else
                begin
                    n.rv[2] = 1'b1;
                end
                n.map = b1[4:0];
                last = b2;
                n.pos = s.pos + 5'd3;
            end
            else if (b == BYTE_VEX2)
            begin
                vex = 1'b1;
                n.ovf = (p1 >= LIMIT_POS);
                n.rv[1] = 1'b1;
                n.rv[4] = ~b1[7];
                n.map = 5'd1;
                last = b1;
                n.pos = p2;
            end
            else
            begin
                n.done = 1'b1;
            end
            if (vex)
            begin
                n.vx = 1'b1;
                n.vvvv = ~last[6:3];
                n.rv[7] = last[2];
                case (last[1:0])
                    2'd1: n.pfx[9] = 1'b1;
                    2'd2: n.pfx[2] = 1'b1;
                    2'd3: n.pfx[1] = 1'b1;
                    default: n.pfx = n.pfx;
                endcase
                if (n.ovf)
                begin
                    n.done = 1'b1;
                end
            end
        end
        return n;
    endfunction

endpackage

// File: sv/ild_prefix.sv
// Legacy prefix scan stage.
`timescale 1ns / 1ps
module ild_prefix
    import ild_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [WIN_BITS-1:0] window,
    output logic                out_valid,
    input  logic                out_ready,
    output scan_t               out_data
);

    logic  valid_reg;
    scan_t data_reg;
    scan_t data_next;

    function automatic logic [11:0] prefix_code(input logic [7:0] b);
        logic [11:0] c;
        case (b)
            8'hf0: c = {1'b1, 11'h001};
            8'hf2: c = {1'b1, 11'h002};
            8'hf3: c = {1'b1, 11'h004};
            8'h26: c = {1'b1, 11'h008};
            8'h2e: c = {1'b1, 11'h010};
            8'h36: c = {1'b1, 11'h020};
            8'h3e: c = {1'b1, 11'h040};
            8'h64: c = {1'b1, 11'h080};
            8'h65: c = {1'b1, 11'h100};
            8'h66: c = {1'b1, 11'h200};
            8'h67: c = {1'b1, 11'h400};
            default: c = 12'h000;
        endcase
        return c;
    endfunction

    always_comb
    begin
        logic found;
        logic [11:0] pc;
        data_next = '0;
        data_next.window = window;
        data_next.pos = LIMIT_POS;
        found = 1'b0;
        for (int i = 0; i < LIMIT_BYTES; i++)
        begin
            pc = prefix_code(window[8*i +: 8]);
            if (!found)
            begin
                if (pc[11])
                begin
                    data_next.pfx = data_next.pfx | pc[10:0];
                end
                else
                begin
                    found = 1'b1;
                    data_next.pos = 5'(i);
                end
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: sv/ild_scan.sv
// REX / VEX / XOP scan stage, a few prefixes per stage.
`timescale 1ns / 1ps
module ild_scan
    import ild_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  scan_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output scan_t out_data
);

    logic  valid_reg;
    scan_t data_reg;
    scan_t data_next;

    always_comb
    begin
        data_next = in_data;
        for (int h = 0; h < HOPS_PER_STAGE; h++)
        begin
            data_next = scan_hop(data_next);
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: sv/ild_opcode.sv
// Escape bytes, opcode fetch and map check.
`timescale 1ns / 1ps
module ild_opcode
    import ild_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  scan_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output opc_t  out_data
);

    logic valid_reg;
    opc_t data_reg;
    opc_t data_next;

    always_comb
    begin
        logic [4:0] p;
        logic [4:0] map;
        logic ov;
        logic [7:0] e;
        p = in_data.pos;
        map = in_data.map;
        ov = (p >= LIMIT_POS);
        e = win_byte(in_data.window, p + 5'd1);
        if (!in_data.vx && win_byte(in_data.window, p) == BYTE_ESC)
        begin
            ov = ov || ((p + 5'd1) >= LIMIT_POS);
            map = 5'd1;
            if (e == BYTE_ESC_38)
            begin
                map = 5'd2;
                p = p + 5'd2;
            end
            else if (e == BYTE_ESC_3A)
            begin
                map = 5'd3;
                p = p + 5'd2;
            end
            else
            begin
                p = p + 5'd1;
            end
        end
        ov = ov || (p >= LIMIT_POS);
        data_next.window = in_data.window;
        data_next.op = win_byte(in_data.window, p);
        data_next.pos = p + 5'd1;
        data_next.map = map;
        data_next.pfx = in_data.pfx;
        data_next.rv = in_data.rv;
        data_next.vvvv = in_data.vvvv;
        data_next.ovf = in_data.ovf || ov;
        if (in_data.ovf)
        begin
            data_next.err = ERR_OVERRUN;
        end
        else if (in_data.vx && (in_data.map == 5'd0 || in_data.map > 5'd3))
        begin
            data_next.err = ERR_MAP;
        end
        else
        begin
            data_next.err = ERR_NONE;
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: sv/ild_operand.sv
// Opcode tables, ModRM and SIB decode.
`timescale 1ns / 1ps
module ild_operand
    import ild_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  opc_t  in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output opnd_t out_data
);

    logic  valid_reg;
    opnd_t data_reg;
    opnd_t data_next;

    always_comb
    begin
        logic [7:0] op;
        logic [3:0] lo;
        logic [3:0] zs;
        logic [3:0] s;
        logic [7:0] m;
        logic [7:0] sb;
        logic [4:0] p;
        logic hm;
        logic sib;
        logic ov;
        logic [3:0] disp;
        logic [3:0] imm;
        logic pic;
        logic [1:0] form;
        op = in_data.op;
        lo = op[3:0];
        zs = in_data.pfx[9] ? 4'd2 : 4'd4;
        s = 4'd0;
        p = in_data.pos;
        m = win_byte(in_data.window, p);
        sb = win_byte(in_data.window, p + 5'd1);
        hm = 1'b0;
        sib = 1'b0;
        ov = 1'b0;
        disp = 4'd0;
        imm = 4'd0;
        pic = 1'b0;
        form = 2'd0;
        case (in_data.map)
            5'd0:
            begin
                case (op[7:4])
                    4'h0, 4'h1, 4'h2, 4'h3:
                    begin
                        if (!op[2]) hm = 1'b1;
                        else if (op[2:0] == 3'd4) imm = 4'd1;
                        else if (op[2:0] == 3'd5) imm = zs;
                    end
                    4'h6:
                    begin
                        hm = (op == 8'h63);
                        if (op[3:2] == 2'd2)
                        begin
                            imm = op[1] ? 4'd1 : zs;
                            if (op[0]) hm = 1'b1;
                        end
                    end
                    4'h7:
                    begin
                        pic = 1'b1;
                        disp = 4'd1;
                    end
                    4'h8:
                    begin
                        hm = 1'b1;
                        if (op[3:2] == 2'd0) imm = (lo != 4'd1) ? 4'd1 : zs;
                    end
                    4'ha:
                    begin
                        if (op[3:2] == 2'd0) disp = in_data.pfx[10] ? 4'd4 : 4'd8;
                        else if (op[3:1] == 3'd4) imm = op[0] ? zs : 4'd1;
                    end
                    4'hb:
                    begin
                        imm = !op[3] ? 4'd1 : (in_data.rv[3] ? 4'd8 : zs);
                    end
                    4'hc:
                    begin
                        hm = !op[3] && (op[2:1] != 2'd1);
                        case (lo)
                            4'd0, 4'd1, 4'd6, 4'd13: imm = 4'd1;
                            4'd2, 4'd10: imm = 4'd2;
                            4'd7: imm = zs;
                            4'd8:
                            begin
                                disp = 4'd2;
                                imm = 4'd1;
                            end
                            default: imm = 4'd0;
                        endcase
                    end
                    4'hd:
                    begin
                        hm = (op[3:2] == 2'd0) || op[3];
                        if (op[3:1] == 3'd2) imm = 4'd1;
                    end
                    4'he:
                    begin
                        if (!op[3] || lo == 4'hb) s = 4'd1;
                        else if (op[3:1] == 3'd4) s = 4'd4;
                        if (s != 4'd0)
                        begin
                            if (!op[2])
                            begin
                                disp = s;
                                pic = 1'b1;
                            end
                            else
                            begin
                                imm = s;
                            end
                        end
                    end
                    4'hf:
                    begin
                        if (op[2:1] == 2'd3)
                        begin
                            hm = 1'b1;
                            if (!op[3] && m[5:3] == 3'd0) imm = op[0] ? zs : 4'd1;
                        end
                    end
                    default: hm = 1'b0;
                endcase
            end
            5'd1:
            begin
                case (op[7:4])
                    4'h0: hm = (lo < 4'd4) || (lo == 4'd13);
                    4'h3: hm = 1'b0;
                    4'h7:
                    begin
                        hm = (lo != 4'd7);
                        if (lo < 4'd4) imm = 4'd1;
                    end
                    4'h8:
                    begin
                        disp = 4'd4;
                        pic = 1'b1;
                    end
                    4'ha:
                    begin
                        hm = (op[2:0] >= 3'd3);
                        if (op[2:0] == 3'd4) imm = 4'd1;
                    end
                    4'hb:
                    begin
                        hm = 1'b1;
                        if (lo == 4'ha) imm = 4'd1;
                    end
                    4'hc:
                    begin
                        if (!op[3])
                        begin
                            hm = 1'b1;
                            if (op[2:0] == 3'd2 || op[2:0] == 3'd4 ||
                                op[2:0] == 3'd5 || op[2:0] == 3'd6)
                            begin
                                imm = 4'd1;
                            end
                        end
                    end
                    default: hm = 1'b1;
                endcase
            end
            5'd2: hm = 1'b1;
            default:
            begin
                hm = 1'b1;
                imm = 4'd1;
            end
        endcase
        if (hm)
        begin
            ov = (p >= LIMIT_POS);
            form = 2'd1;
            if ((m & RIP_MASK) == 8'h05)
            begin
                pic = 1'b1;
                disp = 4'd4;
                p = p + 5'd1;
            end
            else
            begin
                sib = (m[7:6] != 2'd3) && (m[2:0] == 3'd4);
                if (sib)
                begin
                    ov = ov || ((p + 5'd1) >= LIMIT_POS);
                    form = 2'd2;
                    p = p + 5'd2;
                end
                else
                begin
                    p = p + 5'd1;
                end
                case (m[7:6])
                    2'd0: if (sib && sb[2:0] == 3'd5) disp = 4'd4;
                    2'd1: disp = 4'd1;
                    2'd2: disp = 4'd4;
                    default: disp = disp;
                endcase
            end
        end
        data_next.pos = p;
        data_next.op = in_data.op;
        data_next.map = in_data.map;
        data_next.pfx = in_data.pfx;
        data_next.rv = in_data.rv;
        data_next.vvvv = in_data.vvvv;
        data_next.ovf = in_data.ovf || ov;
        data_next.err = in_data.err;
        data_next.disp = disp;
        data_next.imm = imm;
        data_next.pic = pic;
        data_next.form = form;
        data_next.modrm = hm ? m : 8'h00;
    end

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: sv/ild_classify.sv
// Final length, window check, class and output register.
`timescale 1ns / 1ps
module ild_classify
    import ild_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  opnd_t   in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    valid_reg;
    result_t data_reg;
    result_t data_next;

    always_comb
    begin
        logic [5:0] total;
        logic [1:0] err;
        logic [3:0] len;
        logic [2:0] cls;
        logic map0;
        logic map1;
        total = 6'(in_data.pos) + 6'(in_data.disp) + 6'(in_data.imm);
        len = total[3:0];
        map0 = (in_data.map == 5'd0);
        map1 = (in_data.map == 5'd1);
        err = in_data.err;
        if (err == ERR_NONE && (in_data.ovf || total > 6'(LIMIT_BYTES)))
        begin
            err = ERR_OVERRUN;
        end
        if (in_data.op == BYTE_NOP &&
            (len == 4'd1 || (len == 4'd2 && in_data.pfx[9])))
            cls = CLS_NOP;
        else if (in_data.op == BYTE_NOPL && map1)
            cls = CLS_NOP;
        else if (in_data.pic && map0 && in_data.op[7:4] == 4'h7)
            cls = CLS_JCC;
        else if (in_data.pic && map0 && (in_data.op == 8'he9 || in_data.op == 8'heb))
            cls = CLS_JMP;
        else if (in_data.pic && map1 && in_data.op[7:4] == 4'h8)
            cls = CLS_JCC;
        else if (map0 && (in_data.op == 8'he8 ||
                 (in_data.op == 8'hff && in_data.modrm[5:4] == 2'd1)))
            cls = CLS_CALL;
        else if (map0 && in_data.op == 8'h8d)
            cls = CLS_LEA;
        else
            cls = CLS_OTHER;
        data_next = '0;
        data_next.error_code = err;
        if (err == ERR_NONE)
        begin
            data_next.insn_length = len;
            data_next.opcode_byte = in_data.op;
            data_next.opcode_map = in_data.map;
            data_next.prefix_mask = in_data.pfx;
            data_next.rex_vex_mask = in_data.rv;
            data_next.extra_register = in_data.vvvv;
            data_next.modrm_form = in_data.form;
            data_next.disp_bytes = in_data.disp;
            data_next.imm_bytes = in_data.imm;
            data_next.rip_relative = in_data.pic;
            data_next.insn_class = cls;
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: sv/x86_instruction_length_decode.sv
// x86-64 instruction length decoder, eight-stage pipeline, one word per cycle. Stage one
// scans legacy prefixes, four stages each consume up to four REX/VEX/XOP prefixes, then
// one stage handles escapes and the opcode byte, one the opcode tables with ModRM/SIB,
// and the last adds up the length, checks the 15-byte window, classifies and holds the
// result. Every stage has its own valid bit and holds when the stage after it is full,
// so a word is accepted each cycle unless the whole pipeline is backed up.
`timescale 1ns / 1ps
module x86_instruction_length_decode
    import ild_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] window_low,
    input  logic [55:0] window_high,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  insn_length,
    output logic [7:0]  opcode_byte,
    output logic [4:0]  opcode_map,
    output logic [10:0] prefix_mask,
    output logic [7:0]  rex_vex_mask,
    output logic [3:0]  extra_register,
    output logic [1:0]  modrm_form,
    output logic [3:0]  disp_bytes,
    output logic [3:0]  imm_bytes,
    output logic        rip_relative,
    output logic [2:0]  insn_class,
    output logic [1:0]  error_code
);

    logic    scan_valid [SCAN_STAGES+1];
    logic    scan_ready [SCAN_STAGES+1];
    scan_t   scan_data  [SCAN_STAGES+1];
    logic    opc_valid;
    logic    opc_ready;
    opc_t    opc_data;
    logic    opnd_valid;
    logic    opnd_ready;
    opnd_t   opnd_data;
    result_t res;

    ild_prefix u_prefix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .window    ({window_high, window_low}),
        .out_valid (scan_valid[0]),
        .out_ready (scan_ready[0]),
        .out_data  (scan_data[0])
    );

    for (genvar g = 0; g < SCAN_STAGES; g++)
    begin : g_scan
        ild_scan u_scan (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (scan_valid[g]),
            .in_ready  (scan_ready[g]),
            .in_data   (scan_data[g]),
            .out_valid (scan_valid[g+1]),
            .out_ready (scan_ready[g+1]),
            .out_data  (scan_data[g+1])
        );
    end

    ild_opcode u_opcode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scan_valid[SCAN_STAGES]),
        .in_ready  (scan_ready[SCAN_STAGES]),
        .in_data   (scan_data[SCAN_STAGES]),
        .out_valid (opc_valid),
        .out_ready (opc_ready),
        .out_data  (opc_data)
    );

    ild_operand u_operand (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (opc_valid),
        .in_ready  (opc_ready),
        .in_data   (opc_data),
        .out_valid (opnd_valid),
        .out_ready (opnd_ready),
        .out_data  (opnd_data)
    );

    ild_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (opnd_valid),
        .in_ready  (opnd_ready),
        .in_data   (opnd_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res)
    );

    assign insn_length = res.insn_length;
    assign opcode_byte = res.opcode_byte;
    assign opcode_map = res.opcode_map;
    assign prefix_mask = res.prefix_mask;
    assign rex_vex_mask = res.rex_vex_mask;
    assign extra_register = res.extra_register;
    assign modrm_form = res.modrm_form;
    assign disp_bytes = res.disp_bytes;
    assign imm_bytes = res.imm_bytes;
    assign rip_relative = res.rip_relative;
    assign insn_class = res.insn_class;
    assign error_code = res.error_code;

endmodule

// File: tb/tb_top.sv
// Testbench for the x86-64 instruction length decoder: directed and random windows.
`timescale 1ns / 1ps
module tb_top;
    import ild_pkg::*;

    typedef struct {
        logic [3:0]  len;
        logic [7:0]  op;
        logic [4:0]  map;
        logic [10:0] pfx;
        logic [7:0]  rv;
        logic [3:0]  vvvv;
        logic [1:0]  form;
        logic [3:0]  disp;
        logic [3:0]  imm;
        logic        pic;
        logic [2:0]  cls;
        logic [1:0]  err;
    } decode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] window_low;
    logic [55:0] window_high;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  insn_length;
    logic [7:0]  opcode_byte;
    logic [4:0]  opcode_map;
    logic [10:0] prefix_mask;
    logic [7:0]  rex_vex_mask;
    logic [3:0]  extra_register;
    logic [1:0]  modrm_form;
    logic [3:0]  disp_bytes;
    logic [3:0]  imm_bytes;
    logic        rip_relative;
    logic [2:0]  insn_class;
    logic [1:0]  error_code;

    decode_t pending_decodes[$];
    int      mismatches;
    int      hold_off;
    bit      hold_start;
    bit      hold_ack;
    int      hold_left;
    int      sink_wait;
    bit      word_taken;
    bit      sender_gaps;
    bit      sink_gaps;

    x86_instruction_length_decode dut (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // byte fetch with window overrun tracking
    function automatic logic [7:0] code_at(input logic [7:0] w[15], input int p,
                                           inout bit ovr);
        if (p >= LIMIT_BYTES)
        begin
            ovr = 1'b1;
            return 8'h00;
        end
        return w[p];
    endfunction

    function automatic int legacy_bit(input logic [7:0] b);
        case (b)
            8'hf0: return 0;
            8'hf2: return 1;
            8'hf3: return 2;
            8'h26: return 3;
            8'h2e: return 4;
            8'h36: return 5;
            8'h3e: return 6;
            8'h64: return 7;
            8'h65: return 8;
            8'h66: return 9;
            8'h67: return 10;
            default: return -1;
        endcase
    endfunction

    function automatic decode_t decode_window(input logic [63:0] lo, input logic [55:0] hi);
        logic [7:0] w[15];
        decode_t r;
        bit ovr, vx, opsz, asz, rexw, modrm_on;
        int p, bitn;
        logic [7:0] b, b1, b2, last, op, m, sb, e;
        logic [4:0] map;
        logic [10:0] pfx;
        logic [7:0] rv;
        logic [3:0] vvvv, lo4;
        int disp, imm, zs, s;
        bit pic, sib;
        logic [1:0] form, err;
        logic [2:0] cls;
        for (int i = 0; i < 8; i++) w[i] = lo[8*i +: 8];
        for (int i = 0; i < 7; i++) w[8+i] = hi[8*i +: 8];
        ovr = 0; vx = 0; p = 0; pfx = 0; rv = 0; vvvv = 0; map = 0;
        disp = 0; imm = 0; pic = 0; form = 0; err = 0; cls = CLS_OTHER;
        modrm_on = 0; m = 0;
        r = '{default: '0};
        forever
        begin
            bitn = legacy_bit(code_at(w, p, ovr));
            if (bitn < 0) break;
            pfx[bitn] = 1'b1;
            p++;
        end
        forever
        begin
            b = code_at(w, p, ovr);
            if (b[7:4] == REX_HI)
            begin
                rv[0] = 1'b1;
                rv[6:3] = {b[0], b[1], b[2], b[3]};
                p++;
                continue;
            end
            if (b == BYTE_VEX3 || (b == BYTE_XOP && (code_at(w, p+1, ovr) & XOP_SEL_MASK)))
            begin
                b1 = code_at(w, p+1, ovr);
                b2 = code_at(w, p+2, ovr);
                if (b == BYTE_VEX3) rv[1] = 1'b1; else rv[2] = 1'b1;
                rv[6:3] = {~b1[5], ~b1[6], ~b1[7], b2[7]};
                map = b1[4:0];
                last = b2;
                p += 3;
            end
            else if (b == BYTE_VEX2)
            begin
                b1 = code_at(w, p+1, ovr);
                rv[1] = 1'b1;
                rv[4] = ~b1[7];
                map = 5'd1;
                last = b1;
                p += 2;
            end
            else
                break;
            vx = 1'b1;
            vvvv = ~last[6:3];
            rv[7] = last[2];
            case (last[1:0])
                2'd1: pfx[9] = 1'b1;
                2'd2: pfx[2] = 1'b1;
                2'd3: pfx[1] = 1'b1;
                default: ;
            endcase
        end
        if (ovr) err = ERR_OVERRUN;
        else if (vx && (map < 1 || map > 3)) err = ERR_MAP;
        if (err == ERR_NONE)
        begin
            opsz = pfx[9]; asz = pfx[10]; rexw = rv[3];
            zs = opsz ? 2 : 4;
            if (!vx && code_at(w, p, ovr) == BYTE_ESC)
            begin
                p++;
                map = 1;
                e = code_at(w, p, ovr);
                if (e == BYTE_ESC_38) begin map = 2; p++; end
                else if (e == BYTE_ESC_3A) begin map = 3; p++; end
            end
            op = code_at(w, p, ovr);
            p++;
            lo4 = op[3:0];
            if (map == 0)
            begin
                case (op[7:4])
                    4'h0, 4'h1, 4'h2, 4'h3:
                    begin
                        if (!op[2]) modrm_on = 1;
                        else if (op[2:0] == 4) imm = 1;
                        else if (op[2:0] == 5) imm = zs;
                    end
                    4'h6:
                    begin
                        if (op == 8'h63) modrm_on = 1;
                        if (op[3:2] == 2'b10)
                        begin
                            imm = op[1] ? 1 : zs;
                            if (op[0]) modrm_on = 1;
                        end
                    end
                    4'h7: begin pic = 1; disp = 1; end
                    4'h8:
                    begin
                        modrm_on = 1;
                        if (op[3:2] == 0) imm = (lo4 != 1) ? 1 : zs;
                    end
                    4'ha:
                    begin
                        if (op[3:2] == 0) disp = asz ? 4 : 8;
                        else if (op[3:1] == 3'b100) imm = op[0] ? zs : 1;
                    end
                    4'hb: imm = !op[3] ? 1 : (rexw ? 8 : zs);
                    4'hc:
                    begin
                        modrm_on = !op[3] && op[2:1] != 2'b01;
                        case (lo4)
                            0, 1, 6, 13: imm = 1;
                            2, 10: imm = 2;
                            7: imm = zs;
                            8: begin disp = 2; imm = 1; end
                            default: ;
                        endcase
                    end
                    4'hd:
                    begin
                        modrm_on = op[3:2] == 0 || op[3];
                        if (op[3:1] == 3'b010) imm = 1;
                    end
                    4'he:
                    begin
                        s = 0;
                        if (!op[3] || lo4 == 4'hb) s = 1;
                        else if (op[3:1] == 3'b100) s = 4;
                        if (s != 0)
                        begin
                            if (!op[2]) begin disp = s; pic = 1; end
                            else imm = s;
                        end
                    end
                    4'hf:
                        if (op[2:1] == 2'b11)
                        begin
                            modrm_on = 1;
                            if (!op[3])
                            begin
                                m = code_at(w, p, ovr);
                                if (m[5:3] == 0) imm = op[0] ? zs : 1;
                            end
                        end
                    default: ;
                endcase
            end
            else if (map == 1)
            begin
                case (op[7:4])
                    4'h0: modrm_on = lo4 < 4 || lo4 == 13;
                    4'h3: ;
                    4'h7:
                    begin
                        modrm_on = lo4 != 7;
                        if (lo4 < 4) imm = 1;
                    end
                    4'h8: begin disp = 4; pic = 1; end
                    4'ha:
                    begin
                        modrm_on = op[2:0] >= 3;
                        if (op[2:0] == 4) imm = 1;
                    end
                    4'hb:
                    begin
                        modrm_on = 1;
                        if (lo4 == 4'ha) imm = 1;
                    end
                    4'hc:
                        if (!op[3])
                        begin
                            modrm_on = 1;
                            if (op[2:0] inside {2, 4, 5, 6}) imm = 1;
                        end
                    default: modrm_on = 1;
                endcase
            end
            else if (map == 2)
                modrm_on = 1;
            else
            begin
                modrm_on = 1;
                imm = 1;
            end
            if (modrm_on)
            begin
                m = code_at(w, p, ovr);
                form = 1;
                p++;
                if ((m & RIP_MASK) == 8'h05)
                begin
                    pic = 1;
                    disp = 4;
                end
                else
                begin
                    sib = m[7:6] != 2'b11 && m[2:0] == 3'd4;
                    sb = 0;
                    if (sib) begin sb = code_at(w, p, ovr); p++; form = 2; end
                    if (m[7:6] == 0) begin if (sib && sb[2:0] == 5) disp = 4; end
                    else if (m[7:6] == 1) disp = 1;
                    else if (m[7:6] == 2) disp = 4;
                end
            end
            p += disp + imm;
            if (ovr || p > LIMIT_BYTES) err = ERR_OVERRUN;
        end
        if (err != ERR_NONE)
        begin
            r.err = err;
            return r;
        end
        if (op == BYTE_NOP && (p == 1 || (p == 2 && pfx[9]))) cls = CLS_NOP;
        else if (op == BYTE_NOPL && map == 1) cls = CLS_NOP;
        else if (pic && map == 0 && op[7:4] == 4'h7) cls = CLS_JCC;
        else if (pic && map == 0 && (op == 8'he9 || op == 8'heb)) cls = CLS_JMP;
        else if (pic && map == 1 && op[7:4] == 4'h8) cls = CLS_JCC;
        else if (map == 0 && (op == 8'he8 || (op == 8'hff && m[5:4] == 2'b01)))
            cls = CLS_CALL;
        else if (map == 0 && op == 8'h8d) cls = CLS_LEA;
        r.len = p[3:0]; r.op = op; r.map = map; r.pfx = pfx; r.rv = rv; r.vvvv = vvvv;
        r.form = form; r.disp = disp[3:0]; r.imm = imm[3:0]; r.pic = pic; r.cls = cls;
        r.err = ERR_NONE;
        return r;
    endfunction

    // valid stays up past the accepting edge until the next falling edge
    task automatic send_window(input logic [63:0] lo, input logic [55:0] hi);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 14) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        window_low <= lo;
        window_high <= hi;
        in_valid <= 1'b1;
        pending_decodes.push_back(decode_window(lo, hi));
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // packs a byte list into a window, remainder random
    task automatic send_bytes(input logic [7:0] bytes[$]);
        logic [119:0] w;
        w = 120'({$urandom, $urandom, $urandom, $urandom});
        foreach (bytes[i]) if (i < 15) w[8*i +: 8] = bytes[i];
        send_window(w[63:0], w[119:64]);
    endtask

    task automatic wait_drained;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_decodes.size() != 0) @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        decode_t x;
        word_taken <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_decodes.size() == 0)
            begin
                $display("%0t: unexpected word, actual len=%0d err=%0d", $time,
                         insn_length, error_code);
                mismatches++;
            end
            else
            begin
                x = pending_decodes.pop_front();
                if ({insn_length, opcode_byte, opcode_map, prefix_mask, rex_vex_mask,
                     extra_register, modrm_form, disp_bytes, imm_bytes, rip_relative,
                     insn_class, error_code} !==
                    {x.len, x.op, x.map, x.pfx, x.rv, x.vvvv, x.form, x.disp, x.imm,
                     x.pic, x.cls, x.err})
                begin
                    $display({"%0t: mismatch expected len=%0d op=%h map=%0d pfx=%h",
                              " rv=%h v=%h form=%0d disp=%0d imm=%0d rip=%0d",
                              " cls=%0d err=%0d"},
                             $time, x.len, x.op, x.map, x.pfx, x.rv, x.vvvv, x.form,
                             x.disp, x.imm, x.pic, x.cls, x.err);
                    $display({"%0t: mismatch actual   len=%0d op=%h map=%0d pfx=%h",
                              " rv=%h v=%h form=%0d disp=%0d imm=%0d rip=%0d",
                              " cls=%0d err=%0d"},
                             $time, insn_length, opcode_byte, opcode_map, prefix_mask,
                             rex_vex_mask, extra_register, modrm_form, disp_bytes,
                             imm_bytes, rip_relative, insn_class, error_code);
                    mismatches++;
                end
            end
        end
    end

    // receiver: with sink gaps on, a drawn wait after each taken word, or a long hold-off on request
    always @(negedge clk)
    begin
        int draw;
        draw = 0;
        if (hold_start != hold_ack)
        begin
            hold_ack <= hold_start;
            hold_left <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (sink_wait > 0)
        begin
            out_ready <= 1'b0;
            sink_wait <= sink_wait - 1;
        end
        else
        begin
            if (sink_gaps && word_taken) draw = $urandom_range(0, 14);
            if (draw > 0)
            begin
                out_ready <= 1'b0;
                sink_wait <= draw - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed;
        logic [7:0] q[$];
        sender_gaps = 0;
        sink_gaps = 0;
        send_window(64'h0, 56'h0);
        send_window('1, '1);
        q = '{8'h90}; send_bytes(q);
        q = '{8'h66, 8'h90}; send_bytes(q);
        q = '{8'h0f, 8'h1f, 8'h44, 8'h00, 8'h00}; send_bytes(q);
        q = '{8'h48, 8'hb8}; send_bytes(q);
        q = '{8'h8d, 8'h05}; send_bytes(q);
        q = '{8'he8}; send_bytes(q);
        q = '{8'hff, 8'h14, 8'h25}; send_bytes(q);
        q = '{8'h74}; send_bytes(q);
        q = '{8'h0f, 8'h84}; send_bytes(q);
        q = '{8'he9}; send_bytes(q);
        q = '{8'hc5, 8'hf8, 8'h77}; send_bytes(q);
        q = '{8'hc4, 8'he2, 8'h79, 8'h18, 8'hc0}; send_bytes(q);
        q = '{8'hc4, 8'he3, 8'hfd, 8'h0f, 8'hc1, 8'h01}; send_bytes(q);
        q = '{8'hc4, 8'he0, 8'h00}; send_bytes(q);
        q = '{8'h8f, 8'he8, 8'h78, 8'hc2}; send_bytes(q);
        q = '{8'h8f, 8'h00}; send_bytes(q);
        q = '{8'hc5, 8'hf8, 8'h0f, 8'h10, 8'hc0}; send_bytes(q);
        q = '{8'h48, 8'hc5, 8'hf8, 8'h40, 8'h77}; send_bytes(q);
        q = '{8'hf6, 8'h00}; send_bytes(q);
        q = '{8'hf7, 8'h10}; send_bytes(q);
        q = '{8'ha1, 8'h67}; send_bytes(q);
        send_window({8{8'h66}}, {7{8'h66}});
        send_window({8{8'h41}}, {7{8'h41}});
        q = '{8'h0f, 8'h3a, 8'h0f, 8'h84, 8'h25}; send_bytes(q);
        wait_drained();
    endtask

    task automatic test_random;
        logic [7:0] q[$];
        logic [7:0] heads[] = '{8'h66, 8'hf3, 8'hf2, 8'h67, 8'hf0, 8'h2e, 8'h65};
        sender_gaps = 1;
        sink_gaps = 1;
        for (int n = 0; n < 1400; n++)
        begin
            if (n % 200 == 100) sender_gaps = !sender_gaps;
            if (n % 300 == 150) sink_gaps = !sink_gaps;
            q = {};
            if ($urandom_range(0, 9) == 0)
            begin
                send_window({$urandom, $urandom}, 56'({$urandom, $urandom}));
                continue;
            end
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
                q.push_back(heads[$urandom_range(0, 6)]);
            case ($urandom_range(0, 5))
                0: q.push_back(8'(8'h40 | $urandom_range(0, 15)));
                1: begin q.push_back(8'hc5); q.push_back(8'($urandom)); end
                2:
                begin
                    q.push_back($urandom_range(0, 3) == 0 ? 8'h8f : 8'hc4);
                    q.push_back({3'($urandom_range(0, 7)), 5'($urandom_range(0, 4))});
                    q.push_back(8'($urandom));
                end
                default: ;
            endcase
            case ($urandom_range(0, 3))
                0: q.push_back(8'h0f);
                1:
                begin
                    q.push_back(8'h0f);
                    q.push_back($urandom_range(0, 1) ? 8'h38 : 8'h3a);
                end
                default: ;
            endcase
            repeat (8) q.push_back(8'($urandom));
            send_bytes(q);
        end
        wait_drained();
    endtask

    task automatic test_backpressure;
        logic [7:0] q[$];
        sender_gaps = 0;
        sink_gaps = 0;
        @(negedge clk);
        hold_off = 60;
        hold_start = !hold_start;
        for (int n = 0; n < 30; n++)
        begin
            q = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
            send_bytes(q);
        end
        wait_drained();
        repeat (12) @(negedge clk);
    endtask

    initial
    begin
        mismatches = 0;
        hold_off = 0;
        hold_start = 1'b0;
        sender_gaps = 0;
        sink_gaps = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        window_low = '0;
        window_high = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && pending_decodes.size() == 0)
            $display("x86_instruction_length_decode verification clean");
        else
            $display("x86_instruction_length_decode verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("x86_instruction_length_decode verification failed");
        $finish;
    end

endmodule
